/* sv/trf_pkg.sv */
// shared types and constants for the thermocouple reading filter
package trf_pkg;

   localparam int RAW_W    = 16;
   localparam int TEMP_W   = 13;
   localparam int SIZE_W   = 4;
   localparam int COUNT_W  = 4;
   localparam int INDEX_W  = 3;
   localparam int SUM_W    = 16;
   localparam int OUT_T_W  = 15;
   localparam int FAULT_W  = 2;
   localparam int DIVD_W   = SUM_W + 2;
   localparam int STEP_W   = $clog2(DIVD_W);
   localparam int RSP_W    = 24;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 13;

   localparam logic [SIZE_W-1:0] SIZE_RESET  = 4'd3;
   localparam logic [SIZE_W-1:0] SIZE_MAX    = 4'd8;
   localparam logic [TEMP_W-1:0] LIMIT_RESET = 13'd5400;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLES = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT   = 1'd1;

   // fault codes
   localparam logic [FAULT_W-1:0] FAULT_OPEN  = 2'd0;
   localparam logic [FAULT_W-1:0] FAULT_GND   = 2'd1;
   localparam logic [FAULT_W-1:0] FAULT_VCC   = 2'd2;
   localparam logic [FAULT_W-1:0] FAULT_RANGE = 2'd3;

   typedef enum logic [1:0] {
      ST_ACCEPT,
      ST_DIVIDE,
      ST_LOAD
   } trf_state_type;

   typedef struct packed {
      logic accept;
      logic start_div;
      logic div_step;
      logic load_out;
   } trf_cmd_type;

   typedef struct packed {
      logic group_end;
      logic div_last;
      logic out_free;
   } trf_status_type;

endpackage

/* sv/trf_ctrl.sv */
// controller: sequences sample intake, the divide at group end and the result load
module trf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  trf_pkg::trf_status_type status,
   output trf_pkg::trf_cmd_type    cmd
);

   trf_pkg::trf_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= trf_pkg::ST_ACCEPT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         trf_pkg::ST_ACCEPT: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (status.group_end) begin
                  cmd.start_div = 1'b1;
                  state_in      = trf_pkg::ST_DIVIDE;
               end
            end
         end
         trf_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = trf_pkg::ST_LOAD;
            end
         end
         trf_pkg::ST_LOAD: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = trf_pkg::ST_ACCEPT;
            end
         end
         default: begin
            state_in = trf_pkg::ST_ACCEPT;
         end
      endcase
   end

endmodule

/* sv/trf_datapath.sv */
// datapath: config registers, group accumulators, serial divider and result register
module trf_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [trf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [trf_pkg::CSR_DAT_W-1:0]       csr_data,
   input  logic [trf_pkg::RAW_W-1:0]           req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [trf_pkg::RSP_W-1:0]           rsp_tdata,
   input  trf_pkg::trf_cmd_type                cmd,
   output trf_pkg::trf_status_type             status
);

   logic [trf_pkg::SIZE_W-1:0]  samples_ff;
   logic [trf_pkg::TEMP_W-1:0]  limit_ff;

   logic [trf_pkg::INDEX_W-1:0] index_ff, index_in;
   logic [trf_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [trf_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic [trf_pkg::FAULT_W-1:0] fault_ff, fault_in;

   logic [trf_pkg::DIVD_W-1:0]  dq_ff, dq_in;
   logic [trf_pkg::COUNT_W-1:0] rem_ff, rem_in;
   logic [trf_pkg::COUNT_W-1:0] div_count_ff;
   logic [trf_pkg::FAULT_W-1:0] div_fault_ff;
   logic [trf_pkg::STEP_W-1:0]  step_ff;

   logic                        out_valid_ff;
   logic                        out_good_ff;
   logic [trf_pkg::OUT_T_W-1:0] out_temp_ff;
   logic [trf_pkg::FAULT_W-1:0] out_fault_ff;
   logic [trf_pkg::COUNT_W-1:0] out_count_ff;

   logic [trf_pkg::TEMP_W-1:0]  quarters;
   logic [trf_pkg::SIZE_W-1:0]  group_size;
   logic [trf_pkg::SIZE_W-1:0]  taken;
   logic [trf_pkg::COUNT_W:0]   trial;
   logic                        qbit;
   logic                        count_zero;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         samples_ff <= trf_pkg::SIZE_RESET;
         limit_ff   <= trf_pkg::LIMIT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            trf_pkg::CSR_SAMPLES: samples_ff <= csr_data[trf_pkg::SIZE_W-1:0];
            trf_pkg::CSR_LIMIT:   limit_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // sample classification, fault flags checked open, ground, supply in turn, then the upper limit
   always_comb begin
      quarters = req_tdata[trf_pkg::RAW_W-1:3];
      sum_in   = sum_ff;
      count_in = count_ff;
      fault_in = fault_ff;
      if (req_tdata[2]) begin
         fault_in = trf_pkg::FAULT_OPEN;
      end else if (req_tdata[1]) begin
         fault_in = trf_pkg::FAULT_GND;
      end else if (req_tdata[0]) begin
         fault_in = trf_pkg::FAULT_VCC;
      end else if (quarters > limit_ff) begin
         fault_in = trf_pkg::FAULT_RANGE;
      end else begin
         sum_in   = sum_ff + trf_pkg::SUM_W'(quarters);
         count_in = count_ff + 1'b1;
      end
   end

   always_comb begin
      if (samples_ff == '0) begin
         group_size = trf_pkg::SIZE_W'(1);
      end else if (samples_ff > trf_pkg::SIZE_MAX) begin
         group_size = trf_pkg::SIZE_MAX;
      end else begin
         group_size = samples_ff;
      end
      taken    = trf_pkg::SIZE_W'(index_ff) + 1'b1;
      index_in = taken[trf_pkg::INDEX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
         fault_ff <= trf_pkg::FAULT_OPEN;
      end else if (cmd.accept) begin
         if (cmd.start_div) begin
            index_ff <= '0;
            count_ff <= '0;
            sum_ff   <= '0;
            fault_ff <= trf_pkg::FAULT_OPEN;
         end else begin
            index_ff <= index_in;
            count_ff <= count_in;
            sum_ff   <= sum_in;
            fault_ff <= fault_in;
         end
      end
   end

   // restoring divide of 4*sum by the valid count, one quotient bit per cycle
   always_comb begin
      trial = {rem_ff, dq_ff[trf_pkg::DIVD_W-1]};
      qbit  = (trial >= {1'b0, div_count_ff});
      if (qbit) begin
         rem_in = trf_pkg::COUNT_W'(trial - {1'b0, div_count_ff});
      end else begin
         rem_in = trial[trf_pkg::COUNT_W-1:0];
      end
      dq_in = {dq_ff[trf_pkg::DIVD_W-2:0], qbit};
   end

   always_ff @(posedge clock) begin
      if (cmd.start_div) begin
         dq_ff        <= {sum_in, 2'b00};
         rem_ff       <= '0;
         div_count_ff <= count_in;
         div_fault_ff <= fault_in;
      end else if (cmd.div_step) begin
         dq_ff  <= dq_in;
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (cmd.start_div) begin
         step_ff <= '0;
      end else if (cmd.div_step) begin
         step_ff <= step_ff + 1'b1;
      end
   end

   // result register
   assign count_zero = (div_count_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_good_ff  <= !count_zero;
         out_temp_ff  <= count_zero ? '0 : dq_ff[trf_pkg::OUT_T_W-1:0];
         out_fault_ff <= count_zero ? div_fault_ff : trf_pkg::FAULT_OPEN;
         out_count_ff <= div_count_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_count_ff, out_fault_ff, out_temp_ff, out_good_ff};

   always_comb begin
      status.group_end = (taken >= group_size);
      status.div_last  = (step_ff == trf_pkg::STEP_W'(trf_pkg::DIVD_W - 1));
      status.out_free  = !out_valid_ff || rsp_tready;
   end

endmodule

/* sv/thermocouple_reading_filter.sv */
// Thermocouple reading filter: checks each raw converter word for open-circuit, ground-short,
// supply-short and out-of-range faults, sums the good samples of a group and returns one
// beat per group carrying the average in 1/16 degree (or the last fault when no sample was
// good). A sample that does not close a group is taken without leaving the accept state. The
// sample that closes a group starts a restoring divide (one quotient bit per cycle, divisor
// is the good-sample count) followed by a load of the result register, which waits while the
// previous result beat is still not accepted; no new sample is taken until that load is done.
// Registers: index 0 samples per group (1..8, 0 acts as 1, above 8 as 8), index 1 upper
// limit in quarter degrees.
module thermocouple_reading_filter (
   input  logic                              clock,
   input  logic                              reset,
   // configuration write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [trf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [trf_pkg::CSR_DAT_W-1:0]     csr_data,
   // sample stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [trf_pkg::RAW_W-1:0]         req_tdata,  // [15:0] raw_word
   // reading stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] reading_valid, [15:1] temp_sixteenths, [17:16] fault_code,
   // [21:18] valid_samples, [23:22] zero
   output logic [trf_pkg::RSP_W-1:0]         rsp_tdata
);

   trf_pkg::trf_cmd_type    cmd;
   trf_pkg::trf_status_type status;

   assign csr_ready = 1'b1;

   trf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   trf_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule
